// ===== rtl/first_fit_tile_window_search_top_macros.svh =====
// Assertion macros for the first-fit tile window search block.
`ifndef FIRST_FIT_TILE_WINDOW_SEARCH_TOP_MACROS_SVH
`define FIRST_FIT_TILE_WINDOW_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FFTWS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FFTWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fftws_pkg.sv =====
// Constants, codes and helpers shared by the tile window search block.
package fftws_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CFG_TILE_COUNT    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LUT_PER_TILE  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BRAM_PER_TILE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DSP_PER_TILE  = 3'd4;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_CLB   = 2'd1;
  localparam logic [1:0] KIND_BRAM  = 2'd2;
  localparam logic [1:0] KIND_DSP   = 2'd3;

  localparam int KindsW   = 4;
  localparam int InDataW  = 72;
  localparam int OutDataW = 24;
  localparam int LutW     = 20;
  localparam int AmtW     = 12;
  localparam int TakeW    = 13;

  localparam int CFG_AREA_LO      = 68;
  localparam int CFG_AREA_HI      = 70;
  localparam int CFG_AREA_RESTART = 71;
  localparam int FW_AREA_LO       = 108;
  localparam int FW_AREA_HI       = 125;
  localparam int CFG_ROW_A        = 0;
  localparam int CFG_ROW_B        = 3;
  localparam int FW_ROW_A         = 2;
  localparam int FW_ROW_B         = 3;

  localparam logic [8:0]  TILE_COUNT_RST = 9'd256;
  localparam logic [3:0]  ROW_COUNT_RST  = 4'd4;
  localparam logic [11:0] LUT_PER_RST    = 12'd8;
  localparam logic [11:0] BRAM_PER_RST   = 12'd1;
  localparam logic [11:0] DSP_PER_RST    = 12'd1;

  function automatic logic [TakeW-1:0] col_take(input logic [KindsW-1:0] kinds,
                                                input logic [1:0] want,
                                                input logic [AmtW-1:0] amt);
    logic [TakeW-1:0] acc;
    acc = '0;
    if (kinds[1:0] == want) acc = acc + TakeW'(amt);
    if (kinds[3:2] == want) acc = acc + TakeW'(amt);
    return acc;
  endfunction

endpackage

// ===== rtl/fftws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fftws_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/first_fit_tile_window_search_top.sv =====
// Top level of the first-fit tile window search: tile table, scan sequencer, output register.
// A search word makes N tile visits, one visit per cycle through the tile table's single read port,
// before it loads the output register; N is at most (row_count+1)*tile_count, with each count
// first clamped to 1..ROW_LIMIT or 1..TILE_DEPTH. A search with all needs zero skips the scan.
// The input is ready again the cycle after the result loads; a full output register not being read holds it.
// Reset restores the configuration registers; table entries stay unknown until written.
`include "first_fit_tile_window_search_top_macros.svh"

module first_fit_tile_window_search_top
  import fftws_pkg::*;
#(
  parameter int TILE_DEPTH = 256,
  parameter int ROW_LIMIT  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tile_index[7:0], left_kind[9:8], right_kind[11:10], lut_need[31:12],
  // bram_need[43:32], dsp_need[55:44], begin_tile[63:56], begin_row[66:64]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // opcode[0]
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // placed_row[2:0], first_tile[10:3], last_tile[18:11]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // found[0]
  output logic                m_axis_tuser_o
);

  localparam int AW  = $clog2(TILE_DEPTH);
  localparam int TW0 = $clog2(TILE_DEPTH + 1);
  localparam int CW  = (TW0 > 9) ? TW0 : 9;
  localparam int RW  = $clog2(ROW_LIMIT + 1);
  localparam int RCW = (RW > 4) ? RW : 4;
  localparam int BW  = $clog2((ROW_LIMIT + 1) * TILE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r,
                                            input logic [RW-1:0] lim);
    logic [RW-1:0] n;
    n = r + RW'(1);
    return (n >= lim) ? '0 : n;
  endfunction

  logic [1:0]  state_q, state_d;
  logic [8:0]  tile_count_q;
  logic [3:0]  row_count_q;
  logic [11:0] lut_per_q, bram_per_q, dsp_per_q;

  logic [CW-1:0]   start_q, start_d, len_q, len_d;
  logic [RW-1:0]   row_q, row_d;
  logic [BW-1:0]   count_q, count_d, bound_q, bound_d;
  logic            rst_need_q, rst_need_d;
  logic            found_q, found_d;
  logic [LutW-1:0] nl_q, nl_d, init_l_q, init_l_d;
  logic [AmtW-1:0] nb_q, nb_d, init_b_q, init_b_d, nd_q, nd_d, init_d_q, init_d_d;

  logic                out_valid_q, out_valid_d;
  logic                out_user_q, out_user_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_count_q <= TILE_COUNT_RST;
      row_count_q  <= ROW_COUNT_RST;
      lut_per_q    <= LUT_PER_RST;
      bram_per_q   <= BRAM_PER_RST;
      dsp_per_q    <= DSP_PER_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TILE_COUNT:    tile_count_q <= cfg_data_i[8:0];
        CFG_ROW_COUNT:     row_count_q  <= cfg_data_i[3:0];
        CFG_LUT_PER_TILE:  lut_per_q    <= cfg_data_i;
        CFG_BRAM_PER_TILE: bram_per_q   <= cfg_data_i;
        CFG_DSP_PER_TILE:  dsp_per_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturated row geometry
  logic [CW-1:0]    tc, tc_ext;
  logic [RCW-1:0]   rc_ext, rc_sat;
  logic [RW-1:0]    rc;
  logic [RW:0]      rc_p1;
  logic [RW+CW:0]   bound_prod;

  assign tc_ext = CW'(tile_count_q);
  assign tc = (tile_count_q == '0) ? CW'(1) :
              (tc_ext > CW'(TILE_DEPTH)) ? CW'(TILE_DEPTH) : tc_ext;
  assign rc_ext = RCW'(row_count_q);
  assign rc_sat = (row_count_q == '0) ? RCW'(1) :
                  (rc_ext > RCW'(ROW_LIMIT)) ? RCW'(ROW_LIMIT) : rc_ext;
  assign rc = rc_sat[RW-1:0];
  assign rc_p1 = {1'b0, rc} + (RW+1)'(1);
  assign bound_prod = (RW+CW+1)'(rc_p1) * (RW+CW+1)'(tc);

  // input word fields
  logic [7:0]      in_tile_index, in_begin_tile;
  logic [KindsW-1:0] in_kinds;
  logic [LutW-1:0] in_lut;
  logic [AmtW-1:0] in_bram, in_dsp;
  logic [2:0]      in_begin_row;

  assign in_tile_index = s_axis_tdata_i[7:0];
  assign in_kinds      = s_axis_tdata_i[11:8];
  assign in_lut        = s_axis_tdata_i[31:12];
  assign in_bram       = s_axis_tdata_i[43:32];
  assign in_dsp        = s_axis_tdata_i[55:44];
  assign in_begin_tile = s_axis_tdata_i[63:56];
  assign in_begin_row  = s_axis_tdata_i[66:64];

  logic s_accept;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;

  // start position of a search
  logic [CW-1:0] idx_ext, beg_tile_ext, start_init;
  logic [RW-1:0] beg_row_ext, row0, row_init;
  logic          zero_need;

  assign idx_ext      = CW'(in_tile_index);
  assign beg_tile_ext = CW'(in_begin_tile);
  assign beg_row_ext  = RW'(in_begin_row);
  assign row0         = (beg_row_ext >= rc) ? '0 : beg_row_ext;
  assign start_init   = (beg_tile_ext >= tc) ? '0 : beg_tile_ext;
  assign row_init     = (beg_tile_ext >= tc) ? row_inc(row0, rc) : row0;
  assign zero_need    = (in_lut == '0) && (in_bram == '0) && (in_dsp == '0);

  // tile table
  logic              tbl_we;
  logic [CW-1:0]     pos;
  logic [KindsW-1:0] tile_rd;

  assign tbl_we = s_accept && (s_axis_tuser_i == OP_WRITE) && (idx_ext < CW'(TILE_DEPTH));
  assign pos    = start_q + len_q;

  fftws_ram #(
    .WIDTH(KindsW),
    .DEPTH(TILE_DEPTH)
  ) u_tile_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(idx_ext[AW-1:0]),
    .wdata_i(in_kinds),
    .raddr_i(pos[AW-1:0]),
    .rdata_o(tile_rd)
  );

  // window rules for the tile visited at pos
  logic [CW-1:0] pos_n, len1, v_start, v_len;
  logic [RW-1:0] v_row;
  logic          v_reset;
  logic          cfg_row, fw_row, cov_cfg, cov_fw;

  assign pos_n   = pos + CW'(1);
  assign len1    = len_q + CW'(1);
  assign cfg_row = (row_q == RW'(CFG_ROW_A)) || (row_q == RW'(CFG_ROW_B));
  assign fw_row  = (row_q == RW'(FW_ROW_A)) || (row_q == RW'(FW_ROW_B));
  assign cov_cfg = ((start_q <= CW'(CFG_AREA_LO)) && (CW'(CFG_AREA_LO) <= pos)) ||
                   ((start_q <= CW'(CFG_AREA_HI)) && (CW'(CFG_AREA_HI) <= pos));
  assign cov_fw  = ((start_q <= CW'(FW_AREA_LO)) && (CW'(FW_AREA_LO) <= pos)) ||
                   ((start_q <= CW'(FW_AREA_HI)) && (CW'(FW_AREA_HI) <= pos));

  always_comb begin
    v_start = start_q;
    v_len   = len1;
    v_row   = row_q;
    v_reset = 1'b0;
    if (pos_n >= tc) begin
      v_start = '0;
      v_len   = '0;
      v_row   = row_inc(row_q, rc);
      v_reset = 1'b1;
    end else if (cfg_row && cov_cfg) begin
      v_len   = '0;
      v_reset = 1'b1;
      if (CW'(CFG_AREA_RESTART) >= tc) begin
        v_start = '0;
        v_row   = row_inc(row_q, rc);
      end else begin
        v_start = CW'(CFG_AREA_RESTART);
      end
    end else if (fw_row && cov_fw) begin
      v_start = '0;
      v_len   = '0;
      v_row   = row_inc(row_q, rc);
      v_reset = 1'b1;
    end
  end

  // needs after the visit whose data is back
  logic [TakeW-1:0] sub_l, sub_b, sub_d;
  logic [LutW-1:0]  nl_sub;
  logic [AmtW-1:0]  nb_sub, nd_sub;
  logic             pend, done;

  assign sub_l  = col_take(tile_rd, KIND_CLB, lut_per_q);
  assign sub_b  = col_take(tile_rd, KIND_BRAM, bram_per_q);
  assign sub_d  = col_take(tile_rd, KIND_DSP, dsp_per_q);
  assign nl_sub = (nl_q > LutW'(sub_l)) ? nl_q - LutW'(sub_l) : '0;
  assign nb_sub = ({1'b0, nb_q} > sub_b) ? nb_q - sub_b[AmtW-1:0] : '0;
  assign nd_sub = ({1'b0, nd_q} > sub_d) ? nd_q - sub_d[AmtW-1:0] : '0;
  assign pend   = (count_q != '0);
  assign done   = pend && !rst_need_q && (nl_sub == '0) && (nb_sub == '0) && (nd_sub == '0);

  // result word
  logic [CW-1:0] end_full, win_end;
  logic          out_free;

  assign end_full = start_q + len_q;
  assign win_end  = (end_full == tc) ? end_full - CW'(1) : end_full;
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d    = state_q;
    start_d    = start_q;
    len_d      = len_q;
    row_d      = row_q;
    count_d    = count_q;
    bound_d    = bound_q;
    rst_need_d = rst_need_q;
    found_d    = found_q;
    nl_d       = nl_q;
    nb_d       = nb_q;
    nd_d       = nd_q;
    init_l_d   = init_l_q;
    init_b_d   = init_b_q;
    init_d_d   = init_d_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_user_d  = out_user_q;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept && (s_axis_tuser_i == OP_SEARCH)) begin
          start_d    = start_init;
          len_d      = '0;
          row_d      = row_init;
          count_d    = '0;
          bound_d    = bound_prod[BW-1:0];
          rst_need_d = 1'b0;
          found_d    = 1'b1;
          nl_d       = in_lut;
          nb_d       = in_bram;
          nd_d       = in_dsp;
          init_l_d   = in_lut;
          init_b_d   = in_bram;
          init_d_d   = in_dsp;
          state_d    = zero_need ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (done) begin
          found_d = 1'b1;
          state_d = ST_FIN;
        end else if (count_q >= bound_q) begin
          found_d = 1'b0;
          state_d = ST_FIN;
        end else begin
          if (pend) begin
            nl_d = rst_need_q ? init_l_q : nl_sub;
            nb_d = rst_need_q ? init_b_q : nb_sub;
            nd_d = rst_need_q ? init_d_q : nd_sub;
          end
          start_d    = v_start;
          len_d      = v_len;
          row_d      = v_row;
          rst_need_d = v_reset;
          count_d    = count_q + BW'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_user_d  = found_q;
          out_data_d  = found_q ? {5'b0, win_end[7:0], start_q[7:0], row_q[2:0]} : '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q    <= start_d;
    len_q      <= len_d;
    row_q      <= row_d;
    bound_q    <= bound_d;
    rst_need_q <= rst_need_d;
    found_q    <= found_d;
    nl_q       <= nl_d;
    nb_q       <= nb_d;
    nd_q       <= nd_d;
    init_l_q   <= init_l_d;
    init_b_q   <= init_b_d;
    init_d_q   <= init_d_d;
    out_user_q <= out_user_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tdata_o  = out_data_q;

  `FFTWS_ASSERT(a_count_in_bound, state_q == ST_RUN, count_q <= bound_q, "visit count past bound")
  `FFTWS_ASSERT(a_pos_in_row, state_q == ST_RUN, pos < tc, "scan address past row end")
  `FFTWS_ASSERT(a_row_in_range, state_q == ST_RUN, row_q < rc, "scan row past row count")
  `FFTWS_ASSERT_NEXT(a_fin_loads_out, (state_q == ST_FIN) && out_free, out_valid_q, "no result")

endmodule
